// ----- rtl/bti_pkg.sv -----
// bti_pkg: shared types and constants of the byte tape interpreter.
// Depends on nothing; used by bti_ctrl, bti_dp and byte_tape_interpreter.
`timescale 1ns / 1ps
package bti_pkg;

   localparam int unsigned PROG_DEPTH_DEF = 4096;
   localparam int unsigned TAPE_DEPTH_DEF = 4096;
   localparam int unsigned BUDGET_W = 21;
   localparam logic [BUDGET_W-1:0] RUN_BUDGET = BUDGET_W'(1048576);
   localparam int unsigned TLEN_W = 13;
   localparam logic [TLEN_W-1:0] TLEN_RESET = TLEN_W'(4096);

   localparam logic [7:0] OP_RIGHT = 8'h3E; // >
   localparam logic [7:0] OP_LEFT  = 8'h3C; // <
   localparam logic [7:0] OP_INC   = 8'h2B; // +
   localparam logic [7:0] OP_DEC   = 8'h2D; // -
   localparam logic [7:0] OP_OUT   = 8'h2E; // .
   localparam logic [7:0] OP_IN    = 8'h2C; // ,
   localparam logic [7:0] OP_OPEN  = 8'h5B; // [
   localparam logic [7:0] OP_CLOSE = 8'h5D; // ]

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_START = 2'd2,
      REQ_CONT  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      STS_DONE    = 3'd0,
      STS_OUT     = 3'd1,
      STS_NEED_IN = 3'd2,
      STS_BOUNDS  = 3'd3,
      STS_BRACKET = 3'd4,
      STS_NOINIT  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_OUT  = 2'd1,
      MODE_IN   = 2'd2,
      MODE_RUN  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STOP_ZERO = 2'd0,
      STOP_PC   = 2'd1,
      STOP_LEN  = 2'd2
   } stop_sel_type;

   typedef enum logic [1:0] {
      TSRC_ZERO = 2'd0,
      TSRC_INC  = 2'd1,
      TSRC_DEC  = 2'd2,
      TSRC_IN   = 2'd3
   } tsrc_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FETCH,
      ST_EXEC,
      ST_FRD,
      ST_FCHK,
      ST_BRD,
      ST_BCHK
   } state_type;

   typedef struct packed {
      logic         load_we;
      logic         start_run;
      logic         budget_clr;
      logic         budget_inc;
      logic         pc_inc;
      logic         pc_from_p;
      logic         ptr_clr;
      logic         ptr_inc;
      logic         ptr_dec;
      logic         tape_wr;
      tsrc_type     tape_src;
      logic         clr_cnt_clr;
      logic         clr_step;
      logic         fetch;
      logic         scan_init;
      logic         scan_fwd;
      logic         scan_bwd;
      logic         depth_inc;
      logic         depth_dec;
      logic         emit;
      status_type   status;
      stop_sel_type stop_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic       pc_lt_len;
      logic       budget_done;
      logic [7:0] op;
      logic       cell_zero;
      logic       ptr_top;
      logic       ptr_zero;
      logic       scan_fwd_end;
      logic       scan_bwd_end;
      logic [7:0] scan_byte;
      logic       depth_one;
      logic       clr_last;
   } dp_stat_type;

endpackage

// ----- rtl/bti_ctrl.sv -----
// bti_ctrl: run sequencer of the byte tape interpreter.
// Depends on bti_pkg; drives bti_dp through command and status structs.
`timescale 1ns / 1ps
module bti_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_type,
   input  bti_pkg::dp_stat_type stat,
   output logic                busy,
   output bti_pkg::dp_cmd_type cmd
);
   import bti_pkg::*;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic      init_ff, init_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_IDLE;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         init_ff  <= init_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      init_in  = init_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind_type'(req_type))
                  REQ_LOAD: begin
                     cmd.load_we = 1'b1;
                     cmd.emit    = 1'b1;
                  end
                  REQ_CLEAR: begin
                     cmd.clr_cnt_clr = 1'b1;
                     cmd.ptr_clr     = 1'b1;
                     mode_in         = MODE_IDLE;
                     state_in        = ST_CLEAR;
                  end
                  REQ_START: begin
                     mode_in = MODE_IDLE;
                     if (!init_ff) begin
                        cmd.emit   = 1'b1;
                        cmd.status = STS_NOINIT;
                     end else begin
                        cmd.start_run  = 1'b1;
                        cmd.budget_clr = 1'b1;
                        state_in       = ST_FETCH;
                     end
                  end
                  REQ_CONT: begin
                     if (mode_ff == MODE_IDLE) begin
                        cmd.emit     = 1'b1;
                        cmd.stop_sel = STOP_PC;
                     end else begin
                        cmd.budget_clr = 1'b1;
                        if (mode_ff == MODE_IN) begin
                           cmd.tape_wr  = 1'b1;
                           cmd.tape_src = TSRC_IN;
                        end
                        cmd.pc_inc = (mode_ff != MODE_RUN);
                        state_in   = ST_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.tape_wr  = 1'b1;
            cmd.tape_src = TSRC_ZERO;
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               init_in  = 1'b1;
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            if (!stat.pc_lt_len) begin
               cmd.emit     = 1'b1;
               cmd.stop_sel = STOP_LEN;
               mode_in      = MODE_IDLE;
               state_in     = ST_IDLE;
            end else if (stat.budget_done) begin
               mode_in  = MODE_RUN;
               state_in = ST_IDLE;
            end else begin
               cmd.budget_inc = 1'b1;
               cmd.fetch      = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.stop_sel = STOP_PC;
            cmd.pc_inc   = 1'b1;
            state_in     = ST_FETCH;
            case (stat.op)
               OP_RIGHT: begin
                  if (stat.ptr_top) begin
                     cmd.pc_inc = 1'b0;
                     cmd.emit   = 1'b1;
                     cmd.status = STS_BOUNDS;
                     mode_in    = MODE_IDLE;
                     state_in   = ST_IDLE;
                  end else begin
                     cmd.ptr_inc = 1'b1;
                  end
               end
               OP_LEFT: begin
                  if (stat.ptr_zero) begin
                     cmd.pc_inc = 1'b0;
                     cmd.emit   = 1'b1;
                     cmd.status = STS_BOUNDS;
                     mode_in    = MODE_IDLE;
                     state_in   = ST_IDLE;
                  end else begin
                     cmd.ptr_dec = 1'b1;
                  end
               end
               OP_INC: begin
                  cmd.tape_wr  = 1'b1;
                  cmd.tape_src = TSRC_INC;
               end
               OP_DEC: begin
                  cmd.tape_wr  = 1'b1;
                  cmd.tape_src = TSRC_DEC;
               end
               OP_OUT: begin
                  cmd.pc_inc = 1'b0;
                  cmd.emit   = 1'b1;
                  cmd.status = STS_OUT;
                  mode_in    = MODE_OUT;
                  state_in   = ST_IDLE;
               end
               OP_IN: begin
                  cmd.pc_inc = 1'b0;
                  cmd.emit   = 1'b1;
                  cmd.status = STS_NEED_IN;
                  mode_in    = MODE_IN;
                  state_in   = ST_IDLE;
               end
               OP_OPEN: begin
                  if (stat.cell_zero) begin
                     cmd.pc_inc    = 1'b0;
                     cmd.scan_init = 1'b1;
                     state_in      = ST_FRD;
                  end
               end
               OP_CLOSE: begin
                  if (!stat.cell_zero) begin
                     cmd.pc_inc    = 1'b0;
                     cmd.scan_init = 1'b1;
                     state_in      = ST_BRD;
                  end
               end
               default: ;
            endcase
         end
         ST_FRD: begin
            if (stat.scan_fwd_end) begin
               cmd.emit     = 1'b1;
               cmd.status   = STS_BRACKET;
               cmd.stop_sel = STOP_PC;
               mode_in      = MODE_IDLE;
               state_in     = ST_IDLE;
            end else begin
               cmd.scan_fwd = 1'b1;
               state_in     = ST_FCHK;
            end
         end
         ST_FCHK: begin
            state_in = ST_FRD;
            if (stat.scan_byte == OP_OPEN) begin
               cmd.depth_inc = 1'b1;
            end else if (stat.scan_byte == OP_CLOSE) begin
               if (stat.depth_one) begin
                  cmd.pc_from_p = 1'b1;
                  state_in      = ST_FETCH;
               end else begin
                  cmd.depth_dec = 1'b1;
               end
            end
         end
         ST_BRD: begin
            if (stat.scan_bwd_end) begin
               cmd.emit     = 1'b1;
               cmd.status   = STS_BRACKET;
               cmd.stop_sel = STOP_PC;
               mode_in      = MODE_IDLE;
               state_in     = ST_IDLE;
            end else begin
               cmd.scan_bwd = 1'b1;
               state_in     = ST_BCHK;
            end
         end
         ST_BCHK: begin
            state_in = ST_BRD;
            if (stat.scan_byte == OP_CLOSE) begin
               cmd.depth_inc = 1'b1;
            end else if (stat.scan_byte == OP_OPEN) begin
               if (stat.depth_one) begin
                  cmd.pc_from_p = 1'b1;
                  state_in      = ST_FETCH;
               end else begin
                  cmd.depth_dec = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/bti_dp.sv -----
// bti_dp: datapath of the byte tape interpreter: program and tape memories,
// pointers, scan and budget counters, result register. Depends on bti_pkg.
`timescale 1ns / 1ps
module bti_dp #(
   parameter int unsigned PROG_DEPTH = bti_pkg::PROG_DEPTH_DEF,
   parameter int unsigned TAPE_DEPTH = bti_pkg::TAPE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [12:0]          csr_tape_length,
   input  logic [11:0]          req_prog_addr,
   input  logic [7:0]           req_prog_byte,
   input  logic [12:0]          req_run_length,
   input  logic [7:0]           req_in_byte,
   input  bti_pkg::dp_cmd_type  cmd,
   output bti_pkg::dp_stat_type stat,
   output logic                 rsp_strobe,
   output logic [2:0]           rsp_status,
   output logic [7:0]           rsp_out_byte,
   output logic [12:0]          rsp_stop_address
);
   import bti_pkg::*;

   localparam int unsigned AW  = $clog2(PROG_DEPTH);
   localparam int unsigned PCW = AW + 1;
   localparam int unsigned TW  = $clog2(TAPE_DEPTH);
   localparam int unsigned DW  = PCW + 1;

   logic [7:0] prog_mem [PROG_DEPTH];
   logic [7:0] tape_mem [TAPE_DEPTH];

   logic [TLEN_W-1:0]   tlen_ff;
   logic [PCW-1:0]      pc_ff, pc_in;
   logic [PCW-1:0]      len_ff, len_in;
   logic [PCW-1:0]      p_ff, p_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [TW-1:0]       ptr_ff, ptr_in;
   logic [TW-1:0]       clr_ff, clr_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [7:0]          prog_q_ff;
   logic [7:0]          cell_q_ff;
   logic                strobe_ff;
   logic [2:0]          status_ff;
   logic [7:0]          out_byte_ff;
   logic [12:0]         stop_ff;

   logic [31:0]    lim;
   logic [AW-1:0]  prd_addr;
   logic [TW-1:0]  twr_addr;
   logic [7:0]     twr_data;
   logic [PCW-1:0] stop_val;

   // tape limit clamped to 1..TAPE_DEPTH
   always_comb begin
      lim = 32'(tlen_ff);
      if (lim > 32'(TAPE_DEPTH)) lim = 32'(TAPE_DEPTH);
      if (lim == 32'd0) lim = 32'd1;
   end

   always_comb begin
      pc_in     = pc_ff;
      len_in    = len_ff;
      p_in      = p_ff;
      depth_in  = depth_ff;
      ptr_in    = ptr_ff;
      clr_in    = clr_ff;
      budget_in = budget_ff;
      if (cmd.start_run) begin
         pc_in = '0;
         if (32'(req_run_length) > 32'(PROG_DEPTH)) len_in = PCW'(PROG_DEPTH);
         else len_in = PCW'(req_run_length);
      end
      if (cmd.pc_inc)      pc_in = pc_ff + 1'b1;
      if (cmd.pc_from_p)   pc_in = p_ff + 1'b1;
      if (cmd.ptr_clr)     ptr_in = '0;
      if (cmd.ptr_inc)     ptr_in = ptr_ff + 1'b1;
      if (cmd.ptr_dec)     ptr_in = ptr_ff - 1'b1;
      if (cmd.clr_cnt_clr) clr_in = '0;
      if (cmd.clr_step)    clr_in = clr_ff + 1'b1;
      if (cmd.budget_clr)  budget_in = '0;
      if (cmd.budget_inc)  budget_in = budget_ff + 1'b1;
      if (cmd.scan_init) begin
         p_in     = pc_ff;
         depth_in = DW'(1);
      end
      if (cmd.scan_fwd)  p_in = p_ff + 1'b1;
      if (cmd.scan_bwd)  p_in = p_ff - 1'b1;
      if (cmd.depth_inc) depth_in = depth_ff + 1'b1;
      if (cmd.depth_dec) depth_in = depth_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlen_ff   <= TLEN_RESET;
         pc_ff     <= '0;
         len_ff    <= '0;
         depth_ff  <= '0;
         ptr_ff    <= '0;
         clr_ff    <= '0;
         budget_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_we) tlen_ff <= csr_tape_length;
         pc_ff     <= pc_in;
         len_ff    <= len_in;
         depth_ff  <= depth_in;
         ptr_ff    <= ptr_in;
         clr_ff    <= clr_in;
         budget_ff <= budget_in;
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   // program store: one write port for loads, one read port for fetch and scan
   always_comb begin
      prd_addr = AW'(pc_ff);
      if (cmd.scan_fwd) prd_addr = AW'(p_ff + 1'b1);
      if (cmd.scan_bwd) prd_addr = AW'(p_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we && (32'(req_prog_addr) < 32'(PROG_DEPTH)))
         prog_mem[AW'(req_prog_addr)] <= req_prog_byte;
      if (cmd.fetch || cmd.scan_fwd || cmd.scan_bwd)
         prog_q_ff <= prog_mem[prd_addr];
   end

   // tape: cell at the pointer is read on fetch and written back by the op
   always_comb begin
      twr_addr = ptr_ff;
      case (cmd.tape_src)
         TSRC_ZERO: begin
            twr_addr = clr_ff;
            twr_data = 8'd0;
         end
         TSRC_INC: twr_data = cell_q_ff + 8'd1;
         TSRC_DEC: twr_data = cell_q_ff - 8'd1;
         TSRC_IN:  twr_data = req_in_byte;
         default:  twr_data = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.tape_wr) tape_mem[twr_addr] <= twr_data;
      if (cmd.fetch)   cell_q_ff <= tape_mem[ptr_ff];
   end

   always_comb begin
      case (cmd.stop_sel)
         STOP_PC:  stop_val = pc_ff;
         STOP_LEN: stop_val = len_ff;
         default:  stop_val = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         status_ff   <= cmd.status;
         out_byte_ff <= (cmd.status == STS_OUT) ? cell_q_ff : 8'd0;
         stop_ff     <= 13'(stop_val);
      end
   end

   always_comb begin
      stat.pc_lt_len    = (pc_ff < len_ff);
      stat.budget_done  = (budget_ff == RUN_BUDGET);
      stat.op           = prog_q_ff;
      stat.cell_zero    = (cell_q_ff == 8'd0);
      stat.ptr_top      = ((32'(ptr_ff) + 32'd1) >= lim);
      stat.ptr_zero     = (ptr_ff == '0);
      stat.scan_fwd_end = ((32'(p_ff) + 32'd1) >= 32'(len_ff));
      stat.scan_bwd_end = (p_ff == '0);
      stat.scan_byte    = prog_q_ff;
      stat.depth_one    = (depth_ff == DW'(1));
      stat.clr_last     = (clr_ff == TW'(TAPE_DEPTH - 1));
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_stop_address = stop_ff;

endmodule

// ----- rtl/byte_tape_interpreter.sv -----
// byte_tape_interpreter: top level of the eight-command byte tape interpreter.
// Depends on bti_pkg, bti_ctrl and bti_dp.
`timescale 1ns / 1ps
// One request is taken when start is high and busy low; it gives at most one
// item on the rsp_ ports, shown for exactly one cycle with rsp_strobe, and the
// receiver cannot stall it, so sample it then. Load, continue-while-idle and
// not-initialised requests answer in the cycle after acceptance. A clear sweeps
// the tape one cell a cycle and stays busy until the last cell is cleared. A run
// fetches and then executes each instruction (program and tape reads are
// registered) and reads and then checks each byte of a bracket scan, through the
// single read port of the program store. A run that uses up its instruction
// budget without finishing drops busy and gives no item; a continue resumes it.
module byte_tape_interpreter #(
   parameter int unsigned PROG_DEPTH = bti_pkg::PROG_DEPTH_DEF,
   parameter int unsigned TAPE_DEPTH = bti_pkg::TAPE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_prog_addr,
   input  logic [7:0]  req_prog_byte,
   input  logic [12:0] req_run_length,
   input  logic [7:0]  req_in_byte,
   // result
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic [12:0] rsp_stop_address,
   // tape length register
   input  logic        csr_we,
   input  logic [12:0] csr_tape_length
);
   import bti_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: request decode, pause mode, initialised flag
   bti_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   // memories, pointers, counters and the result register
   bti_dp #(
      .PROG_DEPTH (PROG_DEPTH),
      .TAPE_DEPTH (TAPE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_tape_length  (csr_tape_length),
      .req_prog_addr    (req_prog_addr),
      .req_prog_byte    (req_prog_byte),
      .req_run_length   (req_run_length),
      .req_in_byte      (req_in_byte),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_stop_address (rsp_stop_address)
   );

endmodule
